// ===== sv/audio_capture_pingpong_peak_meter_assert.svh =====
// assertion macros shared by the capture block
`ifndef AUDIO_CAPTURE_PINGPONG_PEAK_METER_ASSERT_SVH
`define AUDIO_CAPTURE_PINGPONG_PEAK_METER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define APC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define APC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/apc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package apc_pkg;

	// buffer geometry
	localparam int unsigned BANK_WORDS = 65536;
	localparam int unsigned WIDX_W     = $clog2(BANK_WORDS + 1);

	// field widths
	localparam int unsigned SAMPLE_W   = 24;
	localparam int unsigned FLOOR_W    = 23;
	localparam int unsigned WINDOW_W   = 16;
	localparam int unsigned STORE_W    = 16;
	localparam int unsigned FLEN_W     = 17;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	// channel modes
	localparam logic [1:0] MODE_MONO   = 2'd0;
	localparam logic [1:0] MODE_STEREO = 2'd1;
	localparam logic [1:0] MODE_QUAD   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL    = 2'd3;

	// reset values of the registers
	localparam logic [1:0]          RST_CHANNEL_MODE  = MODE_STEREO;
	localparam logic [FLOOR_W-1:0]  RST_FLOOR_LEVEL   = 23'd1;
	localparam logic [WINDOW_W-1:0] RST_WINDOW_LENGTH = 16'd4096;
	localparam logic [SAMPLE_W-1:0] RST_CLIP_LEVEL    = 24'd8388608;

	typedef logic [SAMPLE_W-1:0] mag_t;

	// meter settings handed to each meter
	typedef struct packed {
		logic [FLOOR_W-1:0]  floor_level;
		logic [WINDOW_W-1:0] window_length;
	} meter_cfg_t;

	// magnitude of a Q1.23 sample, full scale negative gives 0x800000
	function automatic mag_t mag24(input logic [SAMPLE_W-1:0] x);
		mag24 = x[SAMPLE_W-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic mag_t umax(input mag_t a, input mag_t b);
		umax = (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

// ===== sv/apc_meter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apc_meter (
	input  logic              clk,
	input  logic              arst_n,
	input  apc_pkg::meter_cfg_t cfg,
	input  logic              step,
	input  apc_pkg::mag_t     mag,
	output apc_pkg::mag_t     held_next
);
	import apc_pkg::*;

	mag_t                running_q;
	mag_t                held_q;
	logic [WINDOW_W-1:0] count_q;

	mag_t level;
	logic in_window;

	// floor the magnitude, check whether the window is still open
	assign level     = umax({1'b0, cfg.floor_level}, mag);
	assign in_window = count_q < cfg.window_length;

	// held peak as it stands after this step
	assign held_next = (step && !in_window) ? running_q : held_q;

	// running max, window count and held peak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			held_q    <= '0;
			count_q   <= '0;
		end else if (step) begin
			if (in_window) begin
				running_q <= umax(running_q, level);
				count_q   <= count_q + 1'b1;
			end else begin
				held_q    <= running_q;
				running_q <= level;
				count_q   <= WINDOW_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/audio_capture_pingpong_peak_meter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | signals                         | direction
// ---------+---------------------------------+----------
// in       | in_valid/in_ready, samples, rec | sink
// out      | out_valid/out_ready, results    | source
// cfg      | cfg_valid/cfg_ready, index/data | sink, always ready
//
// one word per cycle sustained: an input register feeds one pass of logic
// into the output register, so each word passes the input then the output register.
// the next word is taken while a finished result waits on out_ready.
// the stages stall only when the output register is held by out_ready low.
// reset clears meters, buffer address and config to defaults; no sweep.

module audio_capture_pingpong_peak_meter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input words
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [apc_pkg::SAMPLE_W-1:0]  sample_a,
	input  logic signed [apc_pkg::SAMPLE_W-1:0]  sample_b,
	input  logic signed [apc_pkg::SAMPLE_W-1:0]  sample_c,
	input  logic signed [apc_pkg::SAMPLE_W-1:0]  sample_d,
	input  logic                                 record_enable,
	// result words
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 store_valid,
	output logic                                 store_bank,
	output logic [apc_pkg::STORE_W-1:0]          store_index,
	output logic                                 flush_valid,
	output logic                                 flush_bank,
	output logic [apc_pkg::FLEN_W-1:0]           flush_length,
	output logic                                 flush_keep_open,
	output logic [apc_pkg::SAMPLE_W-1:0]         peak_left,
	output logic [apc_pkg::SAMPLE_W-1:0]         peak_right,
	output logic                                 clip,
	// register writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [apc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [apc_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import apc_pkg::*;

	`include "audio_capture_pingpong_peak_meter_assert.svh"

	localparam logic [WIDX_W:0] BANK_LIMIT = (WIDX_W + 1)'(BANK_WORDS);

	// config registers
	logic [1:0]          mode_q;
	logic [FLOOR_W-1:0]  floor_q;
	logic [WINDOW_W-1:0] window_q;
	mag_t                clip_level_q;

	// buffer address state
	logic [WIDX_W-1:0] widx_q;
	logic              bank_q;

	// input stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] a_s1, b_s1, c_s1, d_s1;
	logic                rec_s1;

	// output register
	logic                out_valid_q;
	logic                s_valid_q, s_bank_q, f_valid_q, f_bank_q, f_keep_q, clip_q;
	logic [STORE_W-1:0]  s_index_q;
	logic [FLEN_W-1:0]   f_len_q;
	mag_t                pl_q, pr_q;

	logic adv;

	assign cfg_ready = 1'b1;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= RST_CHANNEL_MODE;
			floor_q      <= RST_FLOOR_LEVEL;
			window_q     <= RST_WINDOW_LENGTH;
			clip_level_q <= RST_CLIP_LEVEL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CHANNEL_MODE:  mode_q       <= cfg_data[1:0];
				REG_FLOOR_LEVEL:   floor_q      <= cfg_data[FLOOR_W-1:0];
				REG_WINDOW_LENGTH: window_q     <= cfg_data[WINDOW_W-1:0];
				REG_CLIP_LEVEL:    clip_level_q <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake of the two stages
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_s1   <= sample_a;
			b_s1   <= sample_b;
			c_s1   <= sample_c;
			d_s1   <= sample_d;
			rec_s1 <= record_enable;
		end
	end

	// mode decode
	logic       mono, quad;
	logic [2:0] words;

	assign mono  = mode_q == MODE_MONO;
	assign quad  = mode_q[1];
	assign words = mono ? 3'd1 : (quad ? 3'd4 : 3'd2);

	// meter inputs
	mag_t       ma, mb, mc, md, mag_l, mag_r, held_l, held_r;
	meter_cfg_t mcfg;

	assign ma    = mag24(a_s1);
	assign mb    = mag24(b_s1);
	assign mc    = mag24(c_s1);
	assign md    = mag24(d_s1);
	assign mag_l = quad ? umax(ma, mc) : ma;
	assign mag_r = quad ? umax(mb, md) : mb;
	assign mcfg  = '{floor_level: floor_q, window_length: window_q};

	apc_meter u_meter_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (mcfg),
		.step      (adv),
		.mag       (mag_l),
		.held_next (held_l)
	);

	apc_meter u_meter_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (mcfg),
		.step      (adv && !mono),
		.mag       (mag_r),
		.held_next (held_r)
	);

	// ping-pong addressing
	logic [WIDX_W:0]   words_x, wsum0, wsum1;
	logic [WIDX_W-1:0] wi1, wi2, widx_d;
	logic              over0, over1, bank1, bank_d;
	logic              s_valid, s_bank, f_valid, f_bank, f_keep;
	logic [WIDX_W-1:0] s_index, f_len;

	always_comb begin
		words_x = (WIDX_W + 1)'(words);
		wsum0   = {1'b0, widx_q} + words_x;
		over0   = wsum0 > BANK_LIMIT;
		wi1     = over0 ? '0 : widx_q;
		bank1   = over0 ? ~bank_q : bank_q;
		wi2     = wi1 + WIDX_W'(words);
		wsum1   = {1'b0, wi2} + words_x;
		over1   = !over0 && (wsum1 > BANK_LIMIT);

		s_valid = 1'b0;
		s_bank  = 1'b0;
		s_index = '0;
		f_valid = 1'b0;
		f_bank  = 1'b0;
		f_len   = '0;
		f_keep  = 1'b0;
		widx_d  = widx_q;
		bank_d  = bank_q;

		if (rec_s1) begin
			s_valid = 1'b1;
			s_bank  = bank1;
			s_index = wi1;
			widx_d  = wi2;
			bank_d  = bank1;
			// frame would not fit after a mode change
			if (over0) begin
				f_valid = 1'b1;
				f_bank  = bank_q;
				f_len   = widx_q;
				f_keep  = 1'b1;
			end
			// bank full after this frame
			if (over1) begin
				f_valid = 1'b1;
				f_bank  = bank1;
				f_len   = wi2;
				f_keep  = 1'b1;
				widx_d  = '0;
				bank_d  = ~bank1;
			end
		end else if (widx_q != '0) begin
			// stop with data gathered
			f_valid = 1'b1;
			f_bank  = bank_q;
			f_len   = widx_q;
			widx_d  = '0;
			bank_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
			bank_q <= 1'b0;
		end else if (adv) begin
			widx_q <= widx_d;
			bank_q <= bank_d;
		end
	end

	// peaks and clip after this word
	mag_t pl, pr, top;

	assign pl  = held_l;
	assign pr  = mono ? '0 : held_r;
	assign top = umax(pl, pr);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_valid_q <= s_valid;
			s_bank_q  <= s_bank;
			s_index_q <= STORE_W'(s_index);
			f_valid_q <= f_valid;
			f_bank_q  <= f_bank;
			f_len_q   <= FLEN_W'(f_len);
			f_keep_q  <= f_keep;
			pl_q      <= pl;
			pr_q      <= pr;
			clip_q    <= top >= clip_level_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign store_valid     = s_valid_q;
	assign store_bank      = s_bank_q;
	assign store_index     = s_index_q;
	assign flush_valid     = f_valid_q;
	assign flush_bank      = f_bank_q;
	assign flush_length    = f_len_q;
	assign flush_keep_open = f_keep_q;
	assign peak_left       = pl_q;
	assign peak_right      = pr_q;
	assign clip            = clip_q;

	// checks
	`APC_ASSERT_NOW(a_widx_bound, 1'b1, {1'b0, widx_q} <= BANK_LIMIT, "write index past bank end")
	`APC_ASSERT_NOW(a_stop_no_store, out_valid_q && f_valid_q && !f_keep_q, !s_valid_q, "stop flush with store")
	`APC_ASSERT_NOW(a_keep_nonempty, out_valid_q && f_valid_q && f_keep_q, f_len_q != '0, "handoff flush of empty bank")
	`APC_ASSERT_NEXT(a_stop_bank0, adv && f_valid && !f_keep, bank_q == 1'b0 && widx_q == '0, "stop did not return to bank 0")
	`APC_ASSERT_NOW(a_stall_full, !in_ready, valid_s1 && out_valid_q, "input stalled with free stage")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import apc_pkg::*;

	// mode code 3 has no name in the package and behaves as quad
	localparam logic [1:0] MODE_UNDEF = 2'd3;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 24'd8388608;
	localparam logic [SAMPLE_W-1:0] CLIP_NEVER = 24'hFFFFFF;
	localparam logic [FLOOR_W-1:0]  FLOOR_MAX  = 23'h7FFFFF;
	localparam logic [WINDOW_W-1:0] WINDOW_MAX = 16'hFFFF;

	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_WORDS    = 125;
	localparam int LONG_HOLD      = 250;
	localparam int HOLD_SPACING   = 600;
	localparam int MAX_REPORTS    = 40;

	typedef struct packed {
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		logic [SAMPLE_W-1:0] c;
		logic [SAMPLE_W-1:0] d;
		logic                rec;
	} audio_frame_t;

	typedef struct packed {
		logic                s_valid;
		logic                s_bank;
		logic [STORE_W-1:0]  s_index;
		logic                f_valid;
		logic                f_bank;
		logic [FLEN_W-1:0]   f_length;
		logic                f_keep;
		logic [SAMPLE_W-1:0] peak_l;
		logic [SAMPLE_W-1:0] peak_r;
		logic                clip_flag;
	} capture_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_a = '0;
	logic signed [SAMPLE_W-1:0] sample_b = '0;
	logic signed [SAMPLE_W-1:0] sample_c = '0;
	logic signed [SAMPLE_W-1:0] sample_d = '0;
	logic                       record_enable = 1'b0;

	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                store_valid;
	logic                store_bank;
	logic [STORE_W-1:0]  store_index;
	logic                flush_valid;
	logic                flush_bank;
	logic [FLEN_W-1:0]   flush_length;
	logic                flush_keep_open;
	logic [SAMPLE_W-1:0] peak_left;
	logic [SAMPLE_W-1:0] peak_right;
	logic                clip;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	audio_capture_pingpong_peak_meter dut (.*);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of registers and state
	logic [1:0]          set_mode;
	logic [FLOOR_W-1:0]  set_floor;
	logic [WINDOW_W-1:0] set_window;
	logic [SAMPLE_W-1:0] set_clip;
	logic [FLEN_W-1:0]   wr_index;
	logic                cur_bank;
	logic [SAMPLE_W-1:0] run_peak [2];
	logic [WINDOW_W-1:0] win_count [2];
	logic [SAMPLE_W-1:0] hold_peak [2];

	audio_frame_t    pending_words [$];
	capture_result_t expected_results [$];

	int  items_queued = 0;
	int  items_accepted = 0;
	int  results_seen = 0;
	int  fail_count = 0;
	int  settings_used = 0;
	int  flushes_open = 0;
	int  flushes_closed = 0;
	int  clips_seen = 0;
	int  full_peaks = 0;
	int  holds_done = 0;
	bit  word_taken = 1'b0;

	function automatic logic [SAMPLE_W-1:0] sample_magnitude(input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W:0] wide;
		wide = s[SAMPLE_W-1] ? ((25'd1 << SAMPLE_W) - {1'b0, s}) : {1'b0, s};
		return wide[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] louder(input logic [SAMPLE_W-1:0] x,
			input logic [SAMPLE_W-1:0] y);
		return (x > y) ? x : y;
	endfunction

	// one meter: extend the window or latch the peak and start a new one
	function automatic void update_meter(input int m, input logic [SAMPLE_W-1:0] mag);
		logic [SAMPLE_W-1:0] level;
		level = louder({1'b0, set_floor}, mag);
		if (win_count[m] < set_window) begin
			run_peak[m] = louder(run_peak[m], level);
			win_count[m] = win_count[m] + 1'b1;
		end else begin
			hold_peak[m] = run_peak[m];
			run_peak[m] = level;
			win_count[m] = 16'd1;
		end
	endfunction

	// expected result of one frame, advancing the predictor state
	function automatic capture_result_t predict_capture(input audio_frame_t f);
		capture_result_t r;
		logic [SAMPLE_W-1:0] ma, mb, mc, md, pl, pr;
		logic mono, quad, refit;
		int unsigned words;
		r = '0;
		ma = sample_magnitude(f.a);
		mb = sample_magnitude(f.b);
		mc = sample_magnitude(f.c);
		md = sample_magnitude(f.d);
		mono = (set_mode == MODE_MONO);
		quad = (set_mode == MODE_QUAD) || (set_mode == MODE_UNDEF);
		words = mono ? 1 : (quad ? 4 : 2);

		// meters
		if (quad) begin
			update_meter(0, louder(ma, mc));
			update_meter(1, louder(mb, md));
		end else if (mono) begin
			update_meter(0, ma);
		end else begin
			update_meter(0, ma);
			update_meter(1, mb);
		end

		// ping-pong addressing
		if (f.rec) begin
			refit = 1'b0;
			// frame no longer fits after a mode change
			if (wr_index + words > BANK_WORDS) begin
				r.f_valid = 1'b1;
				r.f_bank = cur_bank;
				r.f_length = wr_index;
				r.f_keep = 1'b1;
				cur_bank = ~cur_bank;
				wr_index = '0;
				refit = 1'b1;
			end
			r.s_valid = 1'b1;
			r.s_bank = cur_bank;
			r.s_index = wr_index[STORE_W-1:0];
			wr_index = FLEN_W'(wr_index + words);
			// bank cannot take another frame
			if (!refit && wr_index + words > BANK_WORDS) begin
				r.f_valid = 1'b1;
				r.f_bank = cur_bank;
				r.f_length = wr_index;
				r.f_keep = 1'b1;
				cur_bank = ~cur_bank;
				wr_index = '0;
			end
		end else if (wr_index != '0) begin
			r.f_valid = 1'b1;
			r.f_bank = cur_bank;
			r.f_length = wr_index;
			r.f_keep = 1'b0;
			wr_index = '0;
			cur_bank = 1'b0;
		end

		pl = hold_peak[0];
		pr = mono ? '0 : hold_peak[1];
		r.peak_l = pl;
		r.peak_r = pr;
		r.clip_flag = (louder(pl, pr) >= set_clip);
		return r;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		end
	endtask

	// accept words into the predictor and check result words
	always @(posedge clk) begin : capture_monitor
		audio_frame_t seen;
		capture_result_t want;
		word_taken = arst_n && in_valid && in_ready;
		if (word_taken) begin
			seen.a = sample_a;
			seen.b = sample_b;
			seen.c = sample_c;
			seen.d = sample_d;
			seen.rec = record_enable;
			expected_results.push_back(predict_capture(seen));
			items_accepted++;
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result word expected none actual store_index %0d",
						$time, store_index);
			end else begin
				want = expected_results.pop_front();
				check_field("store_valid", want.s_valid, store_valid);
				check_field("store_bank", want.s_bank, store_bank);
				check_field("store_index", want.s_index, store_index);
				check_field("flush_valid", want.f_valid, flush_valid);
				check_field("flush_bank", want.f_bank, flush_bank);
				check_field("flush_length", want.f_length, flush_length);
				check_field("flush_keep_open", want.f_keep, flush_keep_open);
				check_field("peak_left", want.peak_l, peak_left);
				check_field("peak_right", want.peak_r, peak_right);
				check_field("clip", want.clip_flag, clip);
				if (want.f_valid && want.f_keep)
					flushes_open++;
				if (want.f_valid && !want.f_keep)
					flushes_closed++;
				if (want.clip_flag)
					clips_seen++;
				if (want.peak_l == FULL_SCALE || want.peak_r == FULL_SCALE)
					full_peaks++;
			end
		end
	end

	// sender: bursts of words with random gaps
	int gap_left = 0;
	int burst_left = 0;

	always @(negedge clk) begin : frame_driver
		audio_frame_t next_word;
		if (!arst_n) begin
			// hold idle through reset
		end else if (in_valid && !word_taken) begin
			// word still on offer
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (pending_words.size() > 0) begin
			next_word = pending_words.pop_front();
			sample_a <= next_word.a;
			sample_b <= next_word.b;
			sample_c <= next_word.c;
			sample_d <= next_word.d;
			record_enable <= next_word.rec;
			in_valid <= 1'b1;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: changing ready pattern plus occasional long hold-offs
	int hold_left = 0;
	int next_hold_at = 150;
	int pattern_left = 0;
	int ready_pct = 100;

	always @(negedge clk) begin : result_sink
		logic take;
		if (hold_left > 0) begin
			hold_left--;
			take = 1'b0;
		end else if (arst_n && items_accepted >= next_hold_at) begin
			hold_left = LONG_HOLD - 1;
			next_hold_at += HOLD_SPACING;
			holds_done++;
			take = 1'b0;
		end else begin
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(16, 96);
				case ($urandom_range(0, 3))
					0: ready_pct = 100;
					1: ready_pct = 90;
					2: ready_pct = 60;
					default: ready_pct = 25;
				endcase
			end else begin
				pattern_left--;
			end
			take = ($urandom_range(1, 100) <= ready_pct);
		end
		out_ready <= take;
	end

	// stimulus helpers
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] v;
		v = SAMPLE_W'($urandom);
		case ($urandom_range(0, 9))
			0: v = SAMPLE_MIN;
			1: v = SAMPLE_MAX;
			2: v = SAMPLE_W'($urandom_range(0, 16));
			3: v = ~v[SAMPLE_W-1:0] + 1'b1;
			default: ;
		endcase
		return v;
	endfunction

	function automatic audio_frame_t random_frame(input int rec_pct);
		audio_frame_t f;
		f.a = pick_sample();
		f.b = pick_sample();
		f.c = pick_sample();
		f.d = pick_sample();
		f.rec = ($urandom_range(1, 100) <= rec_pct);
		return f;
	endfunction

	function automatic logic [1:0] pick_mode();
		case ($urandom_range(0, 3))
			0: return MODE_MONO;
			1: return MODE_STEREO;
			2: return MODE_QUAD;
			default: return MODE_UNDEF;
		endcase
	endfunction

	function automatic logic [FLOOR_W-1:0] pick_floor();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return FLOOR_MAX;
			2: return FLOOR_W'($urandom_range(0, 8388607));
			default: return FLOOR_W'($urandom_range(0, 4096));
		endcase
	endfunction

	function automatic logic [WINDOW_W-1:0] pick_window();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return WINDOW_MAX;
			2: return WINDOW_W'($urandom_range(1, 65535));
			default: return WINDOW_W'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_clip();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return FULL_SCALE;
			2: return CLIP_NEVER;
			default: return SAMPLE_W'($urandom_range(0, 8388608));
		endcase
	endfunction

	task automatic queue_frame(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
			input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] d, input logic rec);
		audio_frame_t f;
		f.a = a;
		f.b = b;
		f.c = c;
		f.d = d;
		f.rec = rec;
		pending_words.push_back(f);
		items_queued++;
	endtask

	task automatic queue_random(input int count, input int rec_pct);
		repeat (count) begin
			pending_words.push_back(random_frame(rec_pct));
			items_queued++;
		end
	endtask

	// every queued word taken and every result back
	task automatic wait_idle();
		do @(negedge clk);
		while (items_accepted != items_queued || expected_results.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_CHANNEL_MODE:  set_mode = value[1:0];
			REG_FLOOR_LEVEL:   set_floor = value[FLOOR_W-1:0];
			REG_WINDOW_LENGTH: set_window = value[WINDOW_W-1:0];
			REG_CLIP_LEVEL:    set_clip = value[SAMPLE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [1:0] mode, input logic [FLOOR_W-1:0] floor_lvl,
			input logic [WINDOW_W-1:0] window, input logic [SAMPLE_W-1:0] clip_lvl);
		write_reg(REG_CHANNEL_MODE, {22'd0, mode});
		write_reg(REG_FLOOR_LEVEL, {1'b0, floor_lvl});
		write_reg(REG_WINDOW_LENGTH, {8'd0, window});
		write_reg(REG_CLIP_LEVEL, clip_lvl);
		@(negedge clk) cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// reset, directed frames, then random phases
	initial begin
		set_mode = RST_CHANNEL_MODE;
		set_floor = RST_FLOOR_LEVEL;
		set_window = RST_WINDOW_LENGTH;
		set_clip = RST_CLIP_LEVEL;
		wr_index = '0;
		cur_bank = 1'b0;
		for (int m = 0; m < 2; m++) begin
			run_peak[m] = '0;
			win_count[m] = '0;
			hold_peak[m] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset settings: stop on an empty bank, record, stop with data
		queue_frame('0, '0, '0, '0, 1'b0);
		queue_frame(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
		queue_frame(24'hFFFFFF, 24'd1, '0, '0, 1'b1);
		queue_frame('0, '0, '0, '0, 1'b0);
		wait_idle();

		// quad with one-sample windows, no floor
		configure(MODE_QUAD, '0, 16'd1, FULL_SCALE);
		queue_frame(SAMPLE_MIN, 24'd1, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
		queue_frame('0, '0, '0, '0, 1'b1);
		queue_frame(24'd1, 24'hFFFFFF, 24'd2, 24'hFFFFFE, 1'b1);
		queue_frame(SAMPLE_MAX, SAMPLE_MIN, 24'hFFFFFF, '0, 1'b1);
		queue_frame('0, '0, '0, '0, 1'b0);
		wait_idle();

		// mono, zero window, top floor, clip always set
		configure(MODE_MONO, FLOOR_MAX, '0, '0);
		queue_frame(24'd5, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
		queue_frame(SAMPLE_MIN, '0, '0, '0, 1'b1);
		queue_frame('0, '0, '0, '0, 1'b0);
		queue_frame(SAMPLE_MAX, SAMPLE_MAX, '0, '0, 1'b1);
		wait_idle();

		// undefined mode acts as quad, longest window, clip never set
		configure(MODE_UNDEF, 23'd100, WINDOW_MAX, CLIP_NEVER);
		queue_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1);
		queue_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
		queue_frame('0, '0, '0, '0, 1'b0);
		wait_idle();

		// random phases: mostly recording runs with occasional stops
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			configure(pick_mode(), pick_floor(), pick_window(), pick_clip());
			queue_random(PHASE_WORDS, 92);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			fail_count++;
			$display("%0t: results left over expected 0 actual %0d", $time,
				expected_results.size());
		end
		$display("checked %0d result words for %0d frames over %0d register settings",
			results_seen, items_accepted, settings_used);
		$display("flushes keep-open %0d closing %0d, clip %0d, full-scale peaks %0d, holds %0d",
			flushes_open, flushes_closed, clips_seen, full_peaks, holds_done);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#(40_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== audio_capture_pingpong_peak_meter.f =====
+incdir+sv
sv/apc_pkg.sv
sv/apc_meter.sv
sv/audio_capture_pingpong_peak_meter.sv
tb/tb.sv
